/* rtl/core/hss_pkg.sv */
// Shared constants and types of the Hermite segment sampler.
`default_nettype none

package hss_pkg;

  // Configuration register widths and reset values
  localparam int SAMPLES_W     = 6;
  localparam int STEP_W        = 17;
  localparam int CFG_DATA_W    = 17;
  localparam int CFG_INDEX_W   = 1;
  localparam int SAMPLES_RESET = 15;
  localparam int STEP_RESET    = 4096;

  // Parameter defaults
  localparam int MAX_SAMPLES_DEF = 62;
  localparam int COORD_WIDTH_DEF = 32;

  // Fixed-point formats
  localparam int             W_W     = 17;        // w in unsigned Q1.16, up to 1.0
  localparam logic [W_W-1:0] ONE_Q16 = 17'h10000;
  localparam int             Q_W     = 53;        // signed Q48 basis terms
  localparam int             B_W     = 26;        // signed Q24 basis values
  localparam int             B_FRAC  = 24;
  localparam int             N_OPS   = 8;         // coordinates per segment

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SAMPLES = 1'b0,
    CFG_STEP    = 1'b1
  } cfg_index_t;

endpackage

`default_nettype wire

/* rtl/core/hermite_segment_sampler_top.sv */
// Top level of the Hermite segment sampler: sequencer and eight-stage point pipeline.
`default_nettype none

// Hermite segment sampler. Each input transaction carries one 2D cubic Hermite
// segment (start point, start tangent, end point, end tangent, all signed Q16.16)
// and a first_segment flag. The block emits the start node (only when the flag
// is set), then samples_per_segment interior points at w = i*step_recip, and
// finally the end node with tlast set; tuser marks nodes. Interior points are
// rounded to Q16.16 and saturated. The sequencer issues one point per cycle
// from its segment register while the pipeline advances (n interior points, n
// being the sample count capped at MAX_SAMPLES) and frees that register only
// after the end node, so a new transaction is taken only once the last point
// of the segment is issued. Points then run through eight register stages
// (issue, w, w^2, w^3, basis, partial products, sums, round and saturate).
// A stall on the output holds the whole pipeline; nothing is lost or repeated.
// Write configuration only while the block is idle; software writes step_recip
// as 1/(count+1) in Q0.16.
module hermite_segment_sampler_top #(
  parameter int MAX_SAMPLES = hss_pkg::MAX_SAMPLES_DEF,
  parameter int COORD_WIDTH = hss_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration write port
  input  wire logic                                 cfg_write,
  input  wire logic [hss_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [hss_pkg::CFG_DATA_W-1:0]       cfg_data,
  // segment input
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // from bit 0: p1_x, p1_y, d1_x, d1_y, p2_x, p2_y, d2_x, d2_y
  input  wire logic [hss_pkg::N_OPS*COORD_WIDTH-1:0] s_axis_tdata,
  // first_segment
  input  wire logic                                 s_axis_tuser,
  // point output
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // from bit 0: out_x, out_y, zero padding to whole bytes
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  // is_node
  output logic                                      m_axis_tuser,
  // last
  output logic                                      m_axis_tlast
);

  localparam int CW      = COORD_WIDTH;
  localparam int IDX_W   = $clog2(MAX_SAMPLES + 1);
  localparam int OUT_W   = ((2*CW+7)/8)*8;
  localparam int W_W     = hss_pkg::W_W;
  localparam int Q_W     = hss_pkg::Q_W;
  localparam int B_W     = hss_pkg::B_W;
  localparam int B_FRAC  = hss_pkg::B_FRAC;
  localparam int N_OPS   = hss_pkg::N_OPS;
  // Operand split: hi = c >> 24 (signed), lo = c mod 2^24 (unsigned)
  localparam int CE_W    = (CW > B_FRAC + 1) ? CW : B_FRAC + 1;
  localparam int HI_W    = CE_W - B_FRAC;
  localparam int LO_W    = B_FRAC + 1;
  localparam int PH_W    = B_W + HI_W;
  localparam int PL_W    = B_W + LO_W;
  localparam int SH_W    = PH_W + 2;
  localparam int SL_W    = PL_W + 2;
  localparam int R_W     = SH_W + 1;

  typedef enum logic [1:0] {
    PH_START,
    PH_INTERIOR,
    PH_END
  } phase_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [hss_pkg::SAMPLES_W-1:0] samples_reg;
  logic [hss_pkg::STEP_W-1:0]    step_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_reg <= hss_pkg::SAMPLES_W'(hss_pkg::SAMPLES_RESET);
      step_reg    <= hss_pkg::STEP_W'(hss_pkg::STEP_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        hss_pkg::CFG_SAMPLES: samples_reg <= cfg_data[hss_pkg::SAMPLES_W-1:0];
        hss_pkg::CFG_STEP:    step_reg    <= cfg_data[hss_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Cap the sample count and the step at their legal maxima
  logic [IDX_W-1:0] n_cap;
  logic [W_W-1:0]   step_cap;

  always_comb begin
    if (samples_reg > hss_pkg::SAMPLES_W'(MAX_SAMPLES)) begin
      n_cap = IDX_W'(MAX_SAMPLES);
    end else begin
      n_cap = samples_reg[IDX_W-1:0];
    end
    if (step_reg > hss_pkg::ONE_Q16) begin
      step_cap = hss_pkg::ONE_Q16;
    end else begin
      step_cap = step_reg[W_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline advance: every stage moves when the output register is free or
  // its point is being taken; otherwise everything holds.
  // ---------------------------------------------------------------------------
  logic adv;
  assign adv = !m_axis_tvalid || m_axis_tready;

  // ---------------------------------------------------------------------------
  // Sequencer: holds one segment; unless stalled, issues its points one per cycle
  // ---------------------------------------------------------------------------
  logic                 seg_valid;
  phase_t               phase;
  logic [IDX_W-1:0]     sample_index;
  logic signed [CW-1:0] seg_c [N_OPS];

  assign s_axis_tready = !seg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid    <= 1'b0;
      phase        <= PH_START;
      sample_index <= '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      seg_valid    <= 1'b1;
      sample_index <= IDX_W'(1);
      if (s_axis_tuser) begin
        phase <= PH_START;
      end else if (n_cap == '0) begin
        phase <= PH_END;
      end else begin
        phase <= PH_INTERIOR;
      end
    end else if (seg_valid && adv) begin
      case (phase)
        PH_START: begin
          phase <= (n_cap == '0) ? PH_END : PH_INTERIOR;
        end
        PH_INTERIOR: begin
          if (sample_index == n_cap) begin
            phase <= PH_END;
          end else begin
            sample_index <= sample_index + IDX_W'(1);
          end
        end
        PH_END: begin
          seg_valid    <= 1'b0;
          sample_index <= '0;
        end
        default: begin
          seg_valid <= 1'b0;
          phase     <= PH_START;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      for (int j = 0; j < N_OPS; j++) begin
        seg_c[j] <= s_axis_tdata[j*CW +: CW];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: issued point
  // ---------------------------------------------------------------------------
  logic                 a_v, a_node, a_last;
  logic [IDX_W-1:0]     a_idx;
  logic signed [CW-1:0] a_c [N_OPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_idx  <= sample_index;
      a_node <= (phase != PH_INTERIOR);
      a_last <= (phase == PH_END);
      a_c    <= seg_c;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage B: w = i*step, saturated at 1.0
  // ---------------------------------------------------------------------------
  logic                   b_v, b_node, b_last;
  logic [W_W-1:0]         b_w;
  logic signed [CW-1:0]   b_c [N_OPS];
  logic [IDX_W+W_W-1:0]   w_prod;

  assign w_prod = (IDX_W+W_W)'(a_idx) * (IDX_W+W_W)'(step_cap);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_node <= a_node;
      b_last <= a_last;
      b_c    <= a_c;
      if (w_prod > (IDX_W+W_W)'(hss_pkg::ONE_Q16)) begin
        b_w <= hss_pkg::ONE_Q16;
      end else begin
        b_w <= w_prod[W_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: w^2 (exact Q32)
  // ---------------------------------------------------------------------------
  logic                 c_v, c_node, c_last;
  logic [W_W-1:0]       c_w;
  logic [2*W_W-1:0]     c_w2;
  logic signed [CW-1:0] c_c [N_OPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (adv) begin
      c_v <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_node <= b_node;
      c_last <= b_last;
      c_c    <= b_c;
      c_w    <= b_w;
      c_w2   <= (2*W_W)'(b_w) * (2*W_W)'(b_w);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage D: w^3 (exact Q48)
  // ---------------------------------------------------------------------------
  logic                 d_v, d_node, d_last;
  logic [W_W-1:0]       d_w;
  logic [2*W_W-1:0]     d_w2;
  logic [3*W_W-1:0]     d_w3;
  logic signed [CW-1:0] d_c [N_OPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_node <= c_node;
      d_last <= c_last;
      d_c    <= c_c;
      d_w    <= c_w;
      d_w2   <= c_w2;
      d_w3   <= (3*W_W)'(c_w2) * (3*W_W)'(c_w);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage E: four basis values, exact in Q48, rounded half up to Q24
  // ---------------------------------------------------------------------------
  logic                  e_v, e_node, e_last;
  logic signed [B_W-1:0] e_b [4];
  logic signed [CW-1:0]  e_c [N_OPS];
  logic signed [Q_W-1:0] bx [4];
  logic signed [Q_W-1:0] br [4];

  always_comb begin
    logic signed [Q_W-1:0] w1s, w2s, w3s;
    w1s = signed'(Q_W'(d_w)) <<< 32;
    w2s = signed'(Q_W'(d_w2)) <<< 16;
    w3s = signed'(Q_W'(d_w3));
    bx[0] = (signed'(Q_W'(1)) <<< 48) - 3 * w2s + 2 * w3s;
    bx[1] = w1s - 2 * w2s + w3s;
    bx[2] = 3 * w2s - 2 * w3s;
    bx[3] = w3s - w2s;
    for (int k = 0; k < 4; k++) begin
      br[k] = (bx[k] + signed'(Q_W'(1) <<< (B_FRAC - 1))) >>> B_FRAC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
    end else if (adv) begin
      e_v <= d_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_node <= d_node;
      e_last <= d_last;
      e_c    <= d_c;
      for (int k = 0; k < 4; k++) begin
        e_b[k] <= br[k][B_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage F: partial products basis * operand hi and lo halves; pick node point
  // ---------------------------------------------------------------------------
  logic                   f_v, f_node, f_last;
  logic signed [PH_W-1:0] f_ph [2][4];
  logic signed [PL_W-1:0] f_pl [2][4];
  logic signed [CW-1:0]   f_nx, f_ny;
  logic signed [HI_W-1:0] op_hi [2][4];
  logic signed [LO_W-1:0] op_lo [2][4];

  always_comb begin
    logic signed [CE_W-1:0] ce;
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 4; k++) begin
        ce          = CE_W'(e_c[2*k + a]);
        op_hi[a][k] = signed'(ce[CE_W-1:B_FRAC]);
        op_lo[a][k] = signed'({1'b0, ce[B_FRAC-1:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (adv) begin
      f_v <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_node <= e_node;
      f_last <= e_last;
      // start node takes p1, end node p2
      f_nx   <= e_last ? e_c[4] : e_c[0];
      f_ny   <= e_last ? e_c[5] : e_c[1];
      for (int a = 0; a < 2; a++) begin
        for (int k = 0; k < 4; k++) begin
          f_ph[a][k] <= e_b[k] * op_hi[a][k];
          f_pl[a][k] <= e_b[k] * op_lo[a][k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage G: sum the high and low products of each axis
  // ---------------------------------------------------------------------------
  logic                   g_v, g_node, g_last;
  logic signed [SH_W-1:0] g_sh [2];
  logic signed [SL_W-1:0] g_sl [2];
  logic signed [CW-1:0]   g_nx, g_ny;
  logic signed [SH_W-1:0] sh_sum [2];
  logic signed [SL_W-1:0] sl_sum [2];

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sh_sum[a] = '0;
      sl_sum[a] = '0;
      for (int k = 0; k < 4; k++) begin
        sh_sum[a] = sh_sum[a] + SH_W'(f_ph[a][k]);
        sl_sum[a] = sl_sum[a] + SL_W'(f_pl[a][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (adv) begin
      g_v <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_node <= f_node;
      g_last <= f_last;
      g_nx   <= f_nx;
      g_ny   <= f_ny;
      g_sh   <= sh_sum;
      g_sl   <= sl_sum;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage H: round to Q16.16, saturate, output register
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0]  out_x, out_y;
  logic signed [CW-1:0]  sat [2];

  always_comb begin
    logic signed [SL_W-1:0] sl_r;
    logic signed [R_W-1:0]  r;
    for (int a = 0; a < 2; a++) begin
      sl_r = (g_sl[a] + signed'(SL_W'(1) <<< (B_FRAC - 1))) >>> B_FRAC;
      r    = R_W'(g_sh[a]) + R_W'(sl_r);
      if ((&r[R_W-1:CW-1]) || !(|r[R_W-1:CW-1])) begin
        sat[a] = r[CW-1:0];
      end else if (r[R_W-1]) begin
        sat[a] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        sat[a] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tuser <= g_node;
      m_axis_tlast <= g_last;
      // nodes pass through unchanged
      out_x        <= g_node ? g_nx : sat[0];
      out_y        <= g_node ? g_ny : sat[1];
    end
  end

  assign m_axis_tdata = OUT_W'({out_y, out_x});

endmodule

`default_nettype wire
